// File: rtl/core/hns_pkg.sv
// Shared types and constants for the held note set with sustain core.
// Holds the cell command codes, the control state enum and the neighbor struct.
// No dependencies.
package hns_pkg;

	localparam int MAX_HELD_DEF = 16;
	localparam int NOTE_W = 7;
	localparam int KIND_W = 2;
	localparam int SPLIT_W = 8;
	localparam int COUNT_OUT_W = 5;
	localparam logic [SPLIT_W-1:0] SPLIT_RESET = 8'd128;

	localparam logic [KIND_W-1:0] KIND_NOTE_ON = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEDAL = 2'd2;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INS,
		OP_CLR,
		OP_MARK,
		OP_DEL,
		OP_CMP
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPACT,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic mark;
		logic occ;
	} nbr_t;

endpackage

// File: rtl/core/hns_if.sv
// Handshake channel interfaces for the held note set with sustain core.
// Depends on hns_pkg for field widths.
interface hns_ev_if;
	logic valid;
	logic ready;
	logic [hns_pkg::KIND_W-1:0] kind;
	logic [hns_pkg::NOTE_W-1:0] note;
	logic pedal_down;

	modport source (output valid, kind, note, pedal_down, input ready);
	modport sink (input valid, kind, note, pedal_down, output ready);
endinterface

interface hns_res_if;
	logic valid;
	logic ready;
	logic [hns_pkg::COUNT_OUT_W-1:0] held_count;
	logic [hns_pkg::NOTE_W-1:0] lowest_note;
	logic [hns_pkg::NOTE_W-1:0] highest_note;
	logic set_changed;

	modport source (output valid, held_count, lowest_note, highest_note, set_changed,
		input ready);
	modport sink (input valid, held_count, lowest_note, highest_note, set_changed,
		output ready);
endinterface

interface hns_cfg_if;
	logic valid;
	logic ready;
	logic [hns_pkg::SPLIT_W-1:0] split_point;

	modport source (output valid, split_point, input ready);
	modport sink (input valid, split_point, output ready);
endinterface

// File: rtl/core/hns_cell.sv
// One cell of the ordered held-note chain: a note, its release mark and the
// local rules for insert, remove and compaction. Depends on hns_pkg.
module hns_cell #(
	parameter bit First = 1'b0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hns_pkg::cell_op_t               op,
	input  logic [hns_pkg::NOTE_W-1:0]      cmd_note,
	input  logic                            occ,
	input  hns_pkg::nbr_t                   left,
	input  hns_pkg::nbr_t                   right,
	input  logic                            kill_in,
	output hns_pkg::nbr_t                   self,
	output logic                            kill_out,
	output logic                            hit
);

	logic [hns_pkg::NOTE_W-1:0] note_q, note_d;
	logic mark_q, mark_d;
	logic lt_left, after_p, at_p, del_shift;

	assign self = '{note: note_q, mark: mark_q, occ: occ};
	assign hit = occ && (note_q == cmd_note);
	// first marked cell at or left of here: shift during compaction
	assign kill_out = kill_in | (occ & mark_q);

	assign lt_left = First ? 1'b1 : (left.occ && (left.note < cmd_note));
	assign after_p = left.occ && (left.note > cmd_note);
	assign at_p = lt_left && (!occ || (note_q > cmd_note));
	assign del_shift = occ && (note_q >= cmd_note);

	always_comb begin
		note_d = note_q;
		mark_d = mark_q;
		case (op)
			hns_pkg::OP_INS: begin
				if (after_p) begin
					note_d = left.note;
					mark_d = left.mark;
				end else if (at_p) begin
					note_d = cmd_note;
					mark_d = 1'b0;
				end
			end
			hns_pkg::OP_CLR: begin
				if (hit) mark_d = 1'b0;
			end
			hns_pkg::OP_MARK: begin
				if (hit) mark_d = 1'b1;
			end
			hns_pkg::OP_DEL: begin
				if (del_shift) begin
					note_d = right.note;
					mark_d = right.mark & right.occ;
				end
			end
			hns_pkg::OP_CMP: begin
				if (kill_out) begin
					note_d = right.note;
					mark_d = right.mark & right.occ;
				end
			end
			default: begin
				note_d = note_q;
				mark_d = mark_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		note_q <= note_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else begin
			mark_q <= mark_d;
		end
	end

endmodule

// File: rtl/core/held_note_set_with_sustain_core.sv
// Held note set with sustain: top level with the cell chain and control.
// Depends on hns_pkg, hns_if (channel interfaces) and hns_cell.
//
// Usage: keyboard events (note on, note off, pedal change) arrive as requests
// on src; each produces exactly one result on dst with the held count, the
// lowest and highest held notes and whether the held set changed. The user
// must write the split point register through cfg only while no event is in
// flight; the block itself does not enforce it. A note event or a pedal press
// is applied to every cell as it is accepted, and its result is registered in
// the report state. A pedal lift removes one marked note per cycle through
// the chain's compaction and, once no mark is left, moves to the report state.
// One event is in the core at a time; the next event is accepted once the core
// is back in idle after the previous result has been registered, as long as
// the output register is free or being drained.
// Reset empties the set, clears all marks, lifts the pedal and sets the split
// point to 128; no clearing pass is needed. If dst stalls, the result holds
// in the output register and src is held off until it is taken.
module held_note_set_with_sustain_core #(
	parameter int MaxHeld = hns_pkg::MAX_HELD_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	hns_ev_if.sink       src,
	hns_res_if.source    dst,
	hns_cfg_if.sink      cfg
);

	localparam int CW = $clog2(MaxHeld + 1);
	localparam int IW = (MaxHeld > 1) ? $clog2(MaxHeld) : 1;

	hns_pkg::state_t state_q, state_d;
	hns_pkg::cell_op_t op, in_op;

	logic [hns_pkg::SPLIT_W-1:0] split_q;
	logic [CW-1:0] count_q;
	logic pedal_q;
	logic changed_q;
	logic out_valid_q;
	logic [hns_pkg::COUNT_OUT_W-1:0] out_count_q;
	logic [hns_pkg::NOTE_W-1:0] out_low_q, out_high_q;
	logic out_changed_q;

	hns_pkg::nbr_t cell_s [MaxHeld];
	logic [MaxHeld:0] kill;
	logic [MaxHeld-1:0] hits;
	logic any_hit, any_mark, full, lower, is_lift, accept, load_out, in_ready;
	logic [IW-1:0] last_idx;

	assign kill[0] = 1'b0;
	assign any_hit = |hits;
	assign any_mark = kill[MaxHeld];
	assign full = (count_q == CW'(MaxHeld));
	assign lower = ({1'b0, src.note} < split_q);
	assign is_lift = (src.kind == hns_pkg::KIND_PEDAL) && pedal_q && !src.pedal_down;
	assign accept = src.valid && in_ready;
	assign src.ready = in_ready;
	assign cfg.ready = 1'b1;
	assign last_idx = IW'(count_q - CW'(1));

	genvar gi;
	generate
		for (gi = 0; gi < MaxHeld; gi++) begin : g_cell
			hns_pkg::nbr_t left_n, right_n;
			logic occ;

			assign occ = (count_q > CW'(gi));
			if (gi == 0) begin : g_first
				assign left_n = '0;
			end else begin : g_mid
				assign left_n = cell_s[gi-1];
			end
			if (gi == MaxHeld - 1) begin : g_last
				assign right_n = '0;
			end else begin : g_inner
				assign right_n = cell_s[gi+1];
			end

			hns_cell #(
				.First(gi == 0)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (op),
				.cmd_note (src.note),
				.occ      (occ),
				.left     (left_n),
				.right    (right_n),
				.kill_in  (kill[gi]),
				.self     (cell_s[gi]),
				.kill_out (kill[gi+1]),
				.hit      (hits[gi])
			);
		end
	endgenerate

	// decode the request into a cell command
	always_comb begin
		in_op = hns_pkg::OP_HOLD;
		case (src.kind)
			hns_pkg::KIND_NOTE_ON: begin
				if (lower) begin
					if (any_hit) in_op = hns_pkg::OP_CLR;
					else if (!full) in_op = hns_pkg::OP_INS;
				end
			end
			hns_pkg::KIND_NOTE_OFF: begin
				if (any_hit) in_op = pedal_q ? hns_pkg::OP_MARK : hns_pkg::OP_DEL;
			end
			default: in_op = hns_pkg::OP_HOLD;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hns_pkg::ST_IDLE: begin
				if (accept) state_d = is_lift ? hns_pkg::ST_COMPACT : hns_pkg::ST_REPORT;
			end
			hns_pkg::ST_COMPACT: begin
				if (!any_mark) state_d = hns_pkg::ST_REPORT;
			end
			hns_pkg::ST_REPORT: state_d = hns_pkg::ST_IDLE;
			default: state_d = hns_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		op = hns_pkg::OP_HOLD;
		load_out = 1'b0;
		unique case (state_q)
			hns_pkg::ST_IDLE: begin
				in_ready = !out_valid_q || dst.ready;
				if (in_ready && src.valid) op = in_op;
			end
			hns_pkg::ST_COMPACT: begin
				if (any_mark) op = hns_pkg::OP_CMP;
			end
			hns_pkg::ST_REPORT: load_out = 1'b1;
			default: op = hns_pkg::OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hns_pkg::ST_IDLE;
			split_q <= hns_pkg::SPLIT_RESET;
			count_q <= '0;
			pedal_q <= 1'b0;
			changed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) split_q <= cfg.split_point;
			if (op == hns_pkg::OP_INS) begin
				count_q <= count_q + CW'(1);
			end else if (op == hns_pkg::OP_DEL || op == hns_pkg::OP_CMP) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				changed_q <= (in_op == hns_pkg::OP_INS) || (in_op == hns_pkg::OP_DEL);
				if (src.kind == hns_pkg::KIND_PEDAL) pedal_q <= src.pedal_down;
			end else if (op == hns_pkg::OP_CMP) begin
				changed_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q <= hns_pkg::COUNT_OUT_W'(count_q);
			out_low_q <= (count_q != '0) ? cell_s[0].note : '0;
			out_high_q <= (count_q != '0) ? cell_s[last_idx].note : '0;
			out_changed_q <= changed_q;
		end
	end

	assign dst.valid = out_valid_q;
	assign dst.held_count = out_count_q;
	assign dst.lowest_note = out_low_q;
	assign dst.highest_note = out_high_q;
	assign dst.set_changed = out_changed_q;

endmodule

// File: rtl/core/hns_checker.sv
// Port-level checks for the held note set with sustain core, bound to the top.
// Depends on hns_pkg and the top level's channel ports.
module hns_checker #(
	parameter int MaxHeld = hns_pkg::MAX_HELD_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [hns_pkg::COUNT_OUT_W-1:0]     held_count,
	input logic [hns_pkg::NOTE_W-1:0]          lowest_note,
	input logic [hns_pkg::NOTE_W-1:0]          highest_note
);

	localparam bit CountExact = (MaxHeld < 32);

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && CountExact && held_count == '0 |-> lowest_note == '0 && highest_note == '0)
		else $error("empty set reports nonzero notes");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held_count != '0 |-> lowest_note <= highest_note)
		else $error("lowest note above highest note");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && CountExact && held_count == 5'd1 |-> lowest_note == highest_note)
		else $error("single held note reports different bounds");

endmodule

bind held_note_set_with_sustain_core hns_checker #(
	.MaxHeld(MaxHeld)
) u_hns_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (dst.valid),
	.out_ready    (dst.ready),
	.held_count   (dst.held_count),
	.lowest_note  (dst.lowest_note),
	.highest_note (dst.highest_note)
);

// File: sim/tb_held_note_set_with_sustain_core.sv
`timescale 1ns / 1ps
// Testbench for held_note_set_with_sustain_core: note and pedal requests against a
// scoreboard fed by a behavioral model of the held note set, split point rewritten per phase.
// Depends on hns_pkg, the hns_if channel interfaces and the core itself.
module tb_held_note_set_with_sustain_core;
	import hns_pkg::*;

	localparam int MAX_HELD = MAX_HELD_DEF;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS = 60;
	localparam int TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] count;
		logic [NOTE_W-1:0] lowest;
		logic [NOTE_W-1:0] highest;
		logic changed;
	} tally_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [NOTE_W-1:0] note;
		logic pd;
		bit known;
		tally_t want;
	} opening_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hns_ev_if ev_ch ();
	hns_res_if res_ch ();
	hns_cfg_if cfg_ch ();

	held_note_set_with_sustain_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src(ev_ch),
		.dst(res_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// behavioral copy of the held set
	logic [NOTE_W-1:0] held_note [MAX_HELD];
	logic held_mark [MAX_HELD];
	int held_total = 0;
	logic pedal_now = 1'b0;
	logic [SPLIT_W-1:0] split_now = SPLIT_RESET;

	tally_t pending_tallies [$];
	opening_row_t opening_rows [$];
	int mismatch_count = 0;
	int src_idle_pct = 0;
	int dst_stall_pct = 0;
	int hold_off_asked = 0;
	int hold_off_taken = 0;
	int hold_off_left = 0;
	int split_plan [PHASES] = '{255, 0, 64, 128, 1, 200, 129, 40};

	function automatic int find_held(input logic [NOTE_W-1:0] n);
		int pos;
		pos = -1;
		for (int i = 0; i < held_total; i++)
			if (pos < 0 && held_note[i] == n) pos = i;
		return pos;
	endfunction

	function automatic void drop_cell(input int idx);
		for (int i = idx; i + 1 < held_total; i++) begin
			held_note[i] = held_note[i + 1];
			held_mark[i] = held_mark[i + 1];
		end
		if (held_total > 0) held_total--;
	endfunction

	function automatic tally_t advance_held_set(input logic [KIND_W-1:0] kind,
		input logic [NOTE_W-1:0] note, input logic pd);
		tally_t t;
		int pos;
		int i;
		logic chg;
		chg = 1'b0;
		case (kind)
			KIND_NOTE_ON: begin
				if ({1'b0, note} < split_now) begin
					pos = find_held(note);
					if (pos >= 0) begin
						held_mark[pos] = 1'b0;
					end else if (held_total < MAX_HELD) begin
						i = held_total;
						while (i > 0 && held_note[i - 1] > note) begin
							held_note[i] = held_note[i - 1];
							held_mark[i] = held_mark[i - 1];
							i--;
						end
						held_note[i] = note;
						held_mark[i] = 1'b0;
						held_total++;
						chg = 1'b1;
					end
				end
			end
			KIND_NOTE_OFF: begin
				pos = find_held(note);
				if (pos >= 0) begin
					if (pedal_now) begin
						held_mark[pos] = 1'b1;
					end else begin
						drop_cell(pos);
						chg = 1'b1;
					end
				end
			end
			KIND_PEDAL: begin
				if (pd != pedal_now) begin
					pedal_now = pd;
					// lift: sweep out every marked note
					if (!pd) begin
						i = 0;
						while (i < held_total) begin
							if (held_mark[i]) begin
								drop_cell(i);
								chg = 1'b1;
							end else begin
								i++;
							end
						end
					end
				end
			end
			default: ;
		endcase
		t.count = held_total[COUNT_OUT_W-1:0];
		t.lowest = (held_total > 0) ? held_note[0] : '0;
		t.highest = (held_total > 0) ? held_note[held_total - 1] : '0;
		t.changed = chg;
		return t;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_PRINTS)
			$display("MISMATCH @%0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic take_tally();
		tally_t w;
		if (pending_tallies.size() == 0) begin
			report_mismatch("result with no request pending", int'(res_ch.held_count), 0);
		end else begin
			w = pending_tallies.pop_front();
			if (res_ch.held_count !== w.count)
				report_mismatch("held_count", int'(res_ch.held_count), int'(w.count));
			if (res_ch.lowest_note !== w.lowest)
				report_mismatch("lowest_note", int'(res_ch.lowest_note), int'(w.lowest));
			if (res_ch.highest_note !== w.highest)
				report_mismatch("highest_note", int'(res_ch.highest_note), int'(w.highest));
			if (res_ch.set_changed !== w.changed)
				report_mismatch("set_changed", int'(res_ch.set_changed), int'(w.changed));
		end
	endtask

	// result side: check, then decide ready for the next edge
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) take_tally();
			if (hold_off_asked != hold_off_taken) begin
				hold_off_taken = hold_off_asked;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= dst_stall_pct);
			end
		end
	end

	task automatic offer_event(input logic [KIND_W-1:0] kind, input logic [NOTE_W-1:0] note,
		input logic pd, input bit known, input tally_t want);
		int gap;
		tally_t t;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < src_idle_pct) gap++;
		if (gap > 0) begin
			ev_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev_ch.valid <= 1'b1;
		ev_ch.kind <= kind;
		ev_ch.note <= note;
		ev_ch.pedal_down <= pd;
		@(posedge clk);
		while (!ev_ch.ready) @(posedge clk);
		t = advance_held_set(kind, note, pd);
		pending_tallies.push_back(known ? want : t);
	endtask

	task automatic write_split(input logic [SPLIT_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.split_point <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		split_now = v;
	endtask

	task automatic wait_drained();
		ev_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_tallies.size() != 0) @(posedge clk);
	endtask

	task automatic plan_row(input logic [KIND_W-1:0] kind, input logic [NOTE_W-1:0] note,
		input logic pd, input int known, input int cnt, input int lo, input int hi,
		input int chg);
		opening_row_t row;
		row.kind = kind;
		row.note = note;
		row.pd = pd;
		row.known = (known != 0);
		row.want.count = COUNT_OUT_W'(cnt);
		row.want.lowest = NOTE_W'(lo);
		row.want.highest = NOTE_W'(hi);
		row.want.changed = 1'(chg);
		opening_rows.push_back(row);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("tb_held_note_set_with_sustain_core: done, errors");
		$finish;
	end

	initial begin
		tally_t none;
		logic [KIND_W-1:0] kind;
		logic [NOTE_W-1:0] note;
		logic pd;
		int r;
		int on_pct;
		int top;
		int win_span;
		int win_lo;
		none = '0;
		for (int i = 0; i < MAX_HELD; i++) begin
			held_note[i] = '0;
			held_mark[i] = 1'b0;
		end
		ev_ch.valid <= 1'b0;
		ev_ch.kind <= KIND_NOTE_ON;
		ev_ch.note <= '0;
		ev_ch.pedal_down <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.split_point <= SPLIT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening table, run at the reset split point with the pedal up
		plan_row(KIND_NOTE_OFF, 7'd5, 1'b0, 1, 0, 0, 0, 0);
		plan_row(KIND_NOTE_ON, 7'd0, 1'b0, 1, 1, 0, 0, 1);
		plan_row(KIND_NOTE_ON, 7'd127, 1'b0, 1, 2, 0, 127, 1);
		plan_row(KIND_NOTE_ON, 7'd127, 1'b1, 1, 2, 0, 127, 0);
		plan_row(KIND_UNUSED, 7'd127, 1'b1, 1, 2, 0, 127, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b0, 1, 2, 0, 127, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b1, 1, 2, 0, 127, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b1, 1, 2, 0, 127, 0);
		plan_row(KIND_NOTE_OFF, 7'd127, 1'b0, 1, 2, 0, 127, 0);
		plan_row(KIND_NOTE_OFF, 7'd127, 1'b0, 1, 2, 0, 127, 0);
		plan_row(KIND_NOTE_OFF, 7'd42, 1'b0, 1, 2, 0, 127, 0);
		plan_row(KIND_NOTE_ON, 7'd85, 1'b0, 1, 3, 0, 127, 1);
		plan_row(KIND_NOTE_OFF, 7'd85, 1'b0, 1, 3, 0, 127, 0);
		plan_row(KIND_NOTE_ON, 7'd85, 1'b0, 1, 3, 0, 127, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b0, 1, 2, 0, 85, 1);
		plan_row(KIND_PEDAL, 7'd0, 1'b0, 1, 2, 0, 85, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b1, 1, 2, 0, 85, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b0, 1, 2, 0, 85, 0);
		plan_row(KIND_NOTE_OFF, 7'd0, 1'b0, 1, 1, 85, 85, 1);
		plan_row(KIND_NOTE_OFF, 7'd85, 1'b0, 1, 0, 0, 0, 1);
		plan_row(KIND_NOTE_OFF, 7'd85, 1'b0, 1, 0, 0, 0, 0);
		plan_row(KIND_NOTE_ON, 7'd42, 1'b0, 1, 1, 42, 42, 1);
		plan_row(KIND_NOTE_ON, 7'd21, 1'b0, 0, 0, 0, 0, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b1, 0, 0, 0, 0, 0);
		plan_row(KIND_NOTE_OFF, 7'd42, 1'b0, 0, 0, 0, 0, 0);
		plan_row(KIND_NOTE_OFF, 7'd21, 1'b0, 0, 0, 0, 0, 0);
		plan_row(KIND_PEDAL, 7'd0, 1'b0, 1, 0, 0, 0, 1);
		foreach (opening_rows[i])
			offer_event(opening_rows[i].kind, opening_rows[i].note, opening_rows[i].pd,
				opening_rows[i].known, opening_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_split(SPLIT_W'((p == 5) ? $urandom_range(2, 254) : split_plan[p]));
			case (p % 4)
				0: begin
					src_idle_pct = 0;
					dst_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 62;
					dst_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					dst_stall_pct = 62;
				end
				default: begin
					src_idle_pct = 19;
					dst_stall_pct = 19;
				end
			endcase
			on_pct = (p % 2 == 0) ? 70 : 40;
			// hold results back while requests keep coming, so the core backs up
			if (p == 0) hold_off_asked++;
			top = (split_now == 0 || split_now > 128) ? 127 : split_now - 1;
			win_span = (top > 23) ? 23 : top;
			win_lo = 0;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == ITEMS_PER_PHASE / 2) wait_drained();
				if (k % 40 == 0) win_lo = $urandom_range(0, top - win_span);
				r = $urandom_range(0, 99);
				if (r < on_pct) begin
					kind = KIND_NOTE_ON;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 60) kind = KIND_NOTE_OFF;
					else if (r < 93) kind = KIND_PEDAL;
					else kind = KIND_UNUSED;
				end
				pd = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 15)
					note = NOTE_W'($urandom_range(0, 127));
				else if (kind == KIND_NOTE_OFF && held_total > 0 && $urandom_range(0, 1))
					note = held_note[$urandom_range(0, held_total - 1)];
				else
					note = NOTE_W'(win_lo + $urandom_range(0, win_span));
				offer_event(kind, note, pd, 1'b0, none);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_held_note_set_with_sustain_core: done, clean");
		end else begin
			$display("tb_held_note_set_with_sustain_core: done, errors");
		end
		$finish;
	end

endmodule
